@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SACC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/sacc_pkg.sv @@
// ----------------------------------------------------------------------------
// sacc_pkg
// shared types and constants of the set-associative cache tag controller
// ----------------------------------------------------------------------------
`default_nettype none

package sacc_pkg;

   // access kind codes
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // statistics counters
   localparam int unsigned COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // controller sequencing
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

@@ sv/set_assoc_cache_tag_controller_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_top
// tag, state and lru controller of a write-back set-associative cache
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | beat contents
//   ---------+-----------+---------------------+---------------------------------
//   req_     | in        | req_valid/req_ready | mode, address
//   rsp_     | out       | rsp_valid/rsp_ready | hit, way, writeback, victim and
//            |           |                     | fill block, hit and miss totals
//
// - one access at a time: the set row is read from the set memory in the
//   cycle after the request beat, then compared, updated and written back
// - the result sits in an output register; the next request beat is taken
//   while it waits, and the lookup stalls only if the previous result is
//   still not taken when the new one is ready
// - reset clears the per-set written flags at once, so no sweep of
//   the set memory follows reset
// - rsp_hit_total and rsp_miss_total are the counts after this access
//
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_tag_controller_top #(
   parameter int unsigned NUM_WAYS     = 4,
   parameter int unsigned INDEX_WIDTH  = 4,
   parameter int unsigned TAG_WIDTH    = 6,
   parameter int unsigned OFFSET_WIDTH = 6
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_ready,
   input  wire logic                                        req_mode,
   input  wire logic [TAG_WIDTH+INDEX_WIDTH+OFFSET_WIDTH-1:0] req_address,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_ready,
   output logic                                             rsp_hit,
   output logic      [$clog2(NUM_WAYS)-1:0]                 rsp_way,
   output logic                                             rsp_writeback,
   output logic      [TAG_WIDTH+INDEX_WIDTH-1:0]            rsp_victim_block,
   output logic      [TAG_WIDTH+INDEX_WIDTH-1:0]            rsp_fill_block,
   output logic      [sacc_pkg::COUNT_WIDTH-1:0]            rsp_hit_total,
   output logic      [sacc_pkg::COUNT_WIDTH-1:0]            rsp_miss_total
);

   localparam int unsigned ADDR_W  = TAG_WIDTH + INDEX_WIDTH + OFFSET_WIDTH;
   localparam int unsigned BLOCK_W = TAG_WIDTH + INDEX_WIDTH;
   localparam int unsigned WAY_W   = $clog2(NUM_WAYS);
   localparam int unsigned RANK_W  = $clog2(NUM_WAYS);
   localparam int unsigned CNT_W   = sacc_pkg::COUNT_WIDTH;

   sacc_pkg::state_type state_ff, state_in;

   // captured request beat
   logic              req_mode_ff;
   logic [ADDR_W-1:0] req_addr_ff;

   // statistics
   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0] miss_cnt_ff, miss_cnt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [WAY_W-1:0]   rsp_way_ff;
   logic               rsp_writeback_ff;
   logic [BLOCK_W-1:0] rsp_victim_ff;
   logic [BLOCK_W-1:0] rsp_fill_ff;
   logic [CNT_W-1:0]   rsp_hit_total_ff;
   logic [CNT_W-1:0]   rsp_miss_total_ff;

   logic req_fire;
   logic commit;

   // set memory read and write-back
   logic [NUM_WAYS-1:0]                 cur_valid, new_valid;
   logic [NUM_WAYS-1:0]                 cur_dirty, new_dirty;
   logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]  cur_tags, new_tags;
   logic [NUM_WAYS-1:0][RANK_W-1:0]     cur_ranks, new_ranks;

   // lookup results
   logic                 lk_hit;
   logic [WAY_W-1:0]     lk_way;
   logic                 lk_evict;
   logic                 lk_writeback;
   logic [TAG_WIDTH-1:0] lk_victim_tag;

   logic [INDEX_WIDTH-1:0] cur_set;
   logic [TAG_WIDTH-1:0]   cur_tag;
   logic [BLOCK_W-1:0]     cur_block;

   assign cur_block = req_addr_ff[ADDR_W-1:OFFSET_WIDTH];
   assign cur_set   = req_addr_ff[OFFSET_WIDTH +: INDEX_WIDTH];
   assign cur_tag   = req_addr_ff[OFFSET_WIDTH+INDEX_WIDTH +: TAG_WIDTH];

   assign req_fire = req_valid && req_ready;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sacc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sacc_pkg::ST_LOOKUP;
            end
         end
         sacc_pkg::ST_LOOKUP: begin
            // hold the row until the result register has room
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = sacc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         sacc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sacc_pkg::ST_LOOKUP: begin
            commit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_mode_ff <= req_mode;
         req_addr_ff <= req_address;
      end
   end

   // ------------------------------------------------------------ set memory
   sacc_set_ram #(
      .NUM_WAYS    (NUM_WAYS),
      .INDEX_WIDTH (INDEX_WIDTH),
      .TAG_WIDTH   (TAG_WIDTH),
      .RANK_WIDTH  (RANK_W)
   ) u_set_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_set   (req_address[OFFSET_WIDTH +: INDEX_WIDTH]),
      .rd_valid (cur_valid),
      .rd_dirty (cur_dirty),
      .rd_tags  (cur_tags),
      .rd_ranks (cur_ranks),
      .wr_en    (commit),
      .wr_set   (cur_set),
      .wr_valid (new_valid),
      .wr_dirty (new_dirty),
      .wr_tags  (new_tags),
      .wr_ranks (new_ranks)
   );

   // ---------------------------------------------------------------- lookup
   sacc_lookup #(
      .NUM_WAYS   (NUM_WAYS),
      .TAG_WIDTH  (TAG_WIDTH),
      .RANK_WIDTH (RANK_W),
      .WAY_WIDTH  (WAY_W)
   ) u_lookup (
      .mode       (req_mode_ff),
      .tag        (cur_tag),
      .cur_valid  (cur_valid),
      .cur_dirty  (cur_dirty),
      .cur_tags   (cur_tags),
      .cur_ranks  (cur_ranks),
      .hit        (lk_hit),
      .way        (lk_way),
      .evict      (lk_evict),
      .writeback  (lk_writeback),
      .victim_tag (lk_victim_tag),
      .new_valid  (new_valid),
      .new_dirty  (new_dirty),
      .new_tags   (new_tags),
      .new_ranks  (new_ranks)
   );

   // ------------------------------------------------------------ statistics
   // saturating counts, bumped when the access commits
   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (commit) begin
         if (lk_hit) begin
            if (hit_cnt_ff != sacc_pkg::COUNT_MAX) begin
               hit_cnt_in = hit_cnt_ff + CNT_W'(1);
            end
         end else begin
            if (miss_cnt_ff != sacc_pkg::COUNT_MAX) begin
               miss_cnt_in = miss_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // -------------------------------------------------------- result register
   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff        <= lk_hit;
         rsp_way_ff        <= lk_way;
         rsp_writeback_ff  <= lk_writeback;
         // victim only when a valid line is replaced
         rsp_victim_ff     <= lk_evict ? {lk_victim_tag, cur_set} : '0;
         rsp_fill_ff       <= lk_hit ? '0 : cur_block;
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way          = rsp_way_ff;
   assign rsp_writeback    = rsp_writeback_ff;
   assign rsp_victim_block = rsp_victim_ff;
   assign rsp_fill_block   = rsp_fill_ff;
   assign rsp_hit_total    = rsp_hit_total_ff;
   assign rsp_miss_total   = rsp_miss_total_ff;

   // ------------------------------------------------------------ assertions
   `SACC_ASSERT_NEXT(a_req_starts_lookup, clock, reset, req_fire,
      state_ff == sacc_pkg::ST_LOOKUP, "request beat did not start a lookup")

   `SACC_ASSERT_NEXT(a_commit_loads_rsp, clock, reset, commit,
      rsp_valid_ff, "committed lookup left no result")

   `SACC_ASSERT_IMPLY(a_hit_no_writeback, clock, reset, rsp_valid_ff && rsp_hit_ff,
      !rsp_writeback_ff && (rsp_fill_ff == '0), "hit result carries miss fields")

   `SACC_ASSERT_NEXT(a_miss_counts, clock, reset, commit && !lk_hit,
      (miss_cnt_ff != $past(miss_cnt_ff)) || (miss_cnt_ff == sacc_pkg::COUNT_MAX),
      "miss not counted")

endmodule

`default_nettype wire

@@ sv/sacc_set_ram.sv @@
// ----------------------------------------------------------------------------
// sacc_set_ram
// one row per set: valid, dirty, tag and recency rank of every way
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_set_ram #(
   parameter int unsigned NUM_WAYS    = 4,
   parameter int unsigned INDEX_WIDTH = 4,
   parameter int unsigned TAG_WIDTH   = 6,
   parameter int unsigned RANK_WIDTH  = 2
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      rd_en,
   input  wire logic [INDEX_WIDTH-1:0]                    rd_set,
   output logic      [NUM_WAYS-1:0]                       rd_valid,
   output logic      [NUM_WAYS-1:0]                       rd_dirty,
   output logic      [NUM_WAYS-1:0][TAG_WIDTH-1:0]        rd_tags,
   output logic      [NUM_WAYS-1:0][RANK_WIDTH-1:0]       rd_ranks,
   input  wire logic                                      wr_en,
   input  wire logic [INDEX_WIDTH-1:0]                    wr_set,
   input  wire logic [NUM_WAYS-1:0]                       wr_valid,
   input  wire logic [NUM_WAYS-1:0]                       wr_dirty,
   input  wire logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]        wr_tags,
   input  wire logic [NUM_WAYS-1:0][RANK_WIDTH-1:0]       wr_ranks
);

   localparam int unsigned NUM_SETS = 1 << INDEX_WIDTH;
   localparam int unsigned ROW_W    = NUM_WAYS * (2 + TAG_WIDTH + RANK_WIDTH);

   logic [ROW_W-1:0]    mem_ff [NUM_SETS];
   logic [NUM_SETS-1:0] row_written_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic                rd_written_ff;

   logic [NUM_WAYS-1:0]                 row_valid;
   logic [NUM_WAYS-1:0]                 row_dirty;
   logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]  row_tags;
   logic [NUM_WAYS-1:0][RANK_WIDTH-1:0] row_ranks;

   // row storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_set] <= {wr_ranks, wr_tags, wr_dirty, wr_valid};
      end
      if (rd_en) begin
         rd_row_ff <= mem_ff[rd_set];
      end
   end

   // per-row written flags stand in for the reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
         rd_written_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_written_ff[wr_set] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= row_written_ff[rd_set];
         end
      end
   end

   assign {row_ranks, row_tags, row_dirty, row_valid} = rd_row_ff;

   always_comb begin
      rd_tags = row_tags;
      if (rd_written_ff) begin
         rd_valid = row_valid;
         rd_dirty = row_dirty;
         rd_ranks = row_ranks;
      end else begin
         rd_valid = '0;
         rd_dirty = '0;
         for (int w = 0; w < NUM_WAYS; w++) begin
            rd_ranks[w] = RANK_WIDTH'(w);
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/sacc_lookup.sv @@
// ----------------------------------------------------------------------------
// sacc_lookup
// tag compare, victim choice and updated row for one access
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_lookup #(
   parameter int unsigned NUM_WAYS   = 4,
   parameter int unsigned TAG_WIDTH  = 6,
   parameter int unsigned RANK_WIDTH = 2,
   parameter int unsigned WAY_WIDTH  = 2
) (
   input  wire logic                                mode,
   input  wire logic [TAG_WIDTH-1:0]                tag,
   input  wire logic [NUM_WAYS-1:0]                 cur_valid,
   input  wire logic [NUM_WAYS-1:0]                 cur_dirty,
   input  wire logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]  cur_tags,
   input  wire logic [NUM_WAYS-1:0][RANK_WIDTH-1:0] cur_ranks,
   output logic                                     hit,
   output logic      [WAY_WIDTH-1:0]                way,
   output logic                                     evict,
   output logic                                     writeback,
   output logic      [TAG_WIDTH-1:0]                victim_tag,
   output logic      [NUM_WAYS-1:0]                 new_valid,
   output logic      [NUM_WAYS-1:0]                 new_dirty,
   output logic      [NUM_WAYS-1:0][TAG_WIDTH-1:0]  new_tags,
   output logic      [NUM_WAYS-1:0][RANK_WIDTH-1:0] new_ranks
);

   logic                  is_write;
   logic [WAY_WIDTH-1:0]  hit_way;
   logic                  found_free;
   logic [WAY_WIDTH-1:0]  free_way;
   logic [WAY_WIDTH-1:0]  lru_way;
   logic [RANK_WIDTH-1:0] old_rank;
   logic                  touch;

   assign is_write = (mode == sacc_pkg::MODE_WRITE);

   // first matching valid way
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit && cur_valid[w] && (cur_tags[w] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_WIDTH'(w);
         end
      end
   end

   // lowest invalid way
   always_comb begin
      found_free = 1'b0;
      free_way   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found_free && !cur_valid[w]) begin
            found_free = 1'b1;
            free_way   = WAY_WIDTH'(w);
         end
      end
   end

   // lowest rank, lowest way on a tie
   always_comb begin
      lru_way = '0;
      for (int w = 1; w < NUM_WAYS; w++) begin
         if (cur_ranks[w] < cur_ranks[lru_way]) begin
            lru_way = WAY_WIDTH'(w);
         end
      end
   end

   always_comb begin
      priority if (hit) begin
         way = hit_way;
      end else if (found_free) begin
         way = free_way;
      end else begin
         way = lru_way;
      end
   end

   assign evict      = !hit && !found_free;
   assign writeback  = evict && cur_dirty[lru_way];
   assign victim_tag = cur_tags[lru_way];
   assign touch      = !hit || is_write;
   assign old_rank   = cur_ranks[way];

   // write-back row
   always_comb begin
      new_valid = cur_valid;
      new_dirty = cur_dirty;
      new_tags  = cur_tags;
      new_ranks = cur_ranks;
      if (!hit) begin
         new_valid[way] = 1'b1;
         new_tags[way]  = tag;
         new_dirty[way] = is_write;
      end else if (is_write) begin
         new_dirty[way] = 1'b1;
      end
      if (touch) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (cur_ranks[w] > old_rank) begin
               new_ranks[w] = cur_ranks[w] - RANK_WIDTH'(1);
            end
         end
         new_ranks[way] = RANK_WIDTH'(NUM_WAYS - 1);
      end
   end

endmodule

`default_nettype wire
